// ===== rtl/ssl_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot table package
// Shared types and constants for the slot table and its chain of slot cells.
// ----------------------------------------------------------------------------
package ssl_pkg;

  // Width of a slot position or a count. It holds the largest capacity (4096).
  localparam int POS_W = 13;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [POS_W-1:0] idx;
  } token_t;

  // Operation broadcast to every cell while a token is in flight.
  typedef struct packed {
    cmd_t             op;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
  } cell_cmd_t;

endpackage

// ===== rtl/ssl_cell.sv =====
// ----------------------------------------------------------------------------
// Slot cell
// Holds one slot of the table and passes the search token to its neighbor.
// ----------------------------------------------------------------------------
module ssl_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter logic [ssl_pkg::POS_W-1:0] INDEX = '0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ssl_pkg::cell_cmd_t     cmd,
  input  logic [VALUE_WIDTH-1:0] key,
  input  ssl_pkg::token_t        tok_in,
  output ssl_pkg::token_t        tok_out,
  output logic                   full
);
  import ssl_pkg::*;

  logic [VALUE_WIDTH-1:0] store;
  logic                   match;
  logic                   take;

  always_comb begin
    case (cmd.op)
      CMD_PUT:    match = !full && (INDEX >= cmd.lo) && (INDEX < cmd.hi);
      CMD_LOOKUP: match = full && (store == key);
      CMD_DELETE: match = full && (INDEX == cmd.lo);
      default:    match = 1'b0;
    endcase
  end

  assign take = tok_in.valid && !tok_in.found && match;

  always_ff @(posedge clk) begin
    if (rst) begin
      full          <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      if (take && cmd.op == CMD_PUT) begin
        full <= 1'b1;
      end else if (take && cmd.op == CMD_DELETE) begin
        full <= 1'b0;
      end
    end
    tok_out.found <= tok_in.found || take;
    tok_out.idx   <= take ? INDEX : tok_in.idx;
  end

  always_ff @(posedge clk) begin
    if (take && cmd.op == CMD_PUT) begin
      store <= key;
    end
  end

endmodule

// ===== rtl/sparse_slot_table.sv =====
// ----------------------------------------------------------------------------
// Sparse slot table
// Fixed table of slots with full flags: burst puts into a slot range,
// lookup of the lowest full slot holding a value, and delete of a slot.
// ----------------------------------------------------------------------------
// Usage: drive one command beat with start high while busy is low; the beat
// is taken at that clock edge. A put beat marked first_of_put opens a range
// of slots at slot spanning range_length slots; later put beats fill the
// next empty slots of that range. A lookup searches value, a delete clears
// slot.
// Every command gives exactly one result, shown for one cycle with done
// high; the receiver cannot stall it. Each command sends a token down a
// chain of CAPACITY slot cells, one cell per cycle, and busy drops in the
// same cycle that done rises: the next beat can be taken at the edge that
// ends the done cycle, so a new command is taken only once the last one,
// of any kind, has given its result.
// Reset empties every slot, closes any open put burst and clears the
// counts; stored values are kept only behind their full flags.
// ----------------------------------------------------------------------------
module sparse_slot_table #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [5:0]  slot,
  input  logic [6:0]  range_length,
  input  logic        first_of_put,
  input  logic        last_of_put,
  input  logic [31:0] value,
  output logic        done,
  output logic        hit,
  output logic [5:0]  result_slot,
  output logic [6:0]  placed_total,
  output logic [6:0]  occupied_count,
  output logic        status,
  output logic        burst_done
);
  import ssl_pkg::*;

  localparam logic [POS_W-1:0] CAP = POS_W'(CAPACITY);

  token_t                 tok [0:CAPACITY];
  token_t                 tok_head;
  logic [CAPACITY-1:0]    full_vec;
  logic [CAPACITY:0]      tok_valid_vec;
  cell_cmd_t              cmd;
  logic [VALUE_WIDTH-1:0] key;
  logic                   last_q;
  logic                   status_q;

  logic [POS_W-1:0] fill_cursor, fill_cursor_next;
  logic [POS_W-1:0] fill_end, fill_end_next;
  logic [POS_W-1:0] burst_placed, burst_placed_next;
  logic [POS_W-1:0] full_count, full_count_next;

  logic             accept;
  logic             finish;
  logic [POS_W-1:0] range_sum;
  logic             range_over;
  logic [POS_W-1:0] range_end;
  cell_cmd_t        cmd_next;
  logic             status_next;
  logic             hit_next;
  logic [5:0]       slot_next;
  logic             done_put_next;

  assign accept     = start && !busy;
  assign finish     = tok[CAPACITY].valid;
  assign range_sum  = POS_W'(slot) + POS_W'(range_length);
  assign range_over = range_sum > CAP;
  assign range_end  = range_over ? CAP : range_sum;

  always_comb begin
    fill_cursor_next  = fill_cursor;
    fill_end_next     = fill_end;
    burst_placed_next = burst_placed;
    full_count_next   = full_count;
    cmd_next          = cmd;
    status_next       = status_q;
    hit_next          = 1'b0;
    slot_next         = '0;
    done_put_next     = 1'b0;
    if (accept) begin
      cmd_next.op = cmd_t'(command);
      cmd_next.lo = POS_W'(slot);
      cmd_next.hi = fill_end;
      status_next = 1'b0;
      if (cmd_t'(command) == CMD_PUT) begin
        cmd_next.lo = fill_cursor;
        if (first_of_put) begin
          status_next       = range_over && (range_length != '0);
          fill_cursor_next  = POS_W'(slot);
          fill_end_next     = range_end;
          burst_placed_next = '0;
          cmd_next.lo       = POS_W'(slot);
          cmd_next.hi       = range_end;
        end
      end
    end else if (finish) begin
      case (cmd.op)
        CMD_PUT: begin
          hit_next      = tok[CAPACITY].found;
          done_put_next = last_q;
          if (tok[CAPACITY].found) begin
            slot_next         = 6'(tok[CAPACITY].idx);
            fill_cursor_next  = tok[CAPACITY].idx + POS_W'(1);
            burst_placed_next = burst_placed + POS_W'(1);
            full_count_next   = full_count + POS_W'(1);
          end else begin
            fill_cursor_next = fill_end;
          end
          if (last_q) begin
            fill_cursor_next = fill_end;
          end
        end
        CMD_LOOKUP: begin
          hit_next = tok[CAPACITY].found;
          if (tok[CAPACITY].found) begin
            slot_next = 6'(tok[CAPACITY].idx);
          end
        end
        CMD_DELETE: begin
          hit_next = tok[CAPACITY].found;
          if (tok[CAPACITY].found) begin
            slot_next       = 6'(tok[CAPACITY].idx);
            full_count_next = full_count - POS_W'(1);
          end
        end
        default: begin
          hit_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      done           <= 1'b0;
      tok_head.valid <= 1'b0;
      fill_cursor    <= '0;
      fill_end       <= '0;
      burst_placed   <= '0;
      full_count     <= '0;
    end else begin
      tok_head.valid <= accept;
      done           <= finish;
      if (accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      fill_cursor  <= fill_cursor_next;
      fill_end     <= fill_end_next;
      burst_placed <= burst_placed_next;
      full_count   <= full_count_next;
    end
    tok_head.found <= 1'b0;
    tok_head.idx   <= '0;
  end

  always_ff @(posedge clk) begin
    cmd          <= cmd_next;
    status_q     <= status_next;
    hit          <= hit_next;
    result_slot  <= slot_next;
    burst_done   <= done_put_next;
    status       <= finish && (cmd.op == CMD_PUT) && status_q;
    if (accept) begin
      key    <= VALUE_WIDTH'(value);
      last_q <= last_of_put;
    end
  end

  assign tok[0]         = tok_head;
  assign placed_total   = 7'(burst_placed);
  assign occupied_count = 7'(full_count);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ssl_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .INDEX      (POS_W'(i))
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .key    (key),
      .tok_in (tok[i]),
      .tok_out(tok[i+1]),
      .full   (full_vec[i])
    );
  end

  for (genvar i = 0; i <= CAPACITY; i++) begin : g_tok_valid
    assign tok_valid_vec[i] = tok[i].valid;
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valid_vec))
    else $error("More than one search token in the cell chain.");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    !busy |-> ($countones(full_vec) == 32'(full_count)))
    else $error("Occupied count disagrees with the full flags.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    full_count <= CAP)
    else $error("Occupied count exceeds the capacity.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !done)
    else $error("Accepted beat did not raise busy.");

  a_slot_zero_on_miss: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> result_slot == '0)
    else $error("Result slot is nonzero on a miss.");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Sparse slot table testbench
// Drives put bursts, lookups and deletes through the start/busy handshake
// and checks every done beat against a cycle-free model of the slot table
// kept inside the bench. A directed part covers the corner cases of a burst
// and of the table, then random traffic made mostly of well-formed bursts
// runs with random send gaps, before and after a directed whole-table fill.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssl_pkg::*;

  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  slot;
    logic [6:0]  range_length;
    logic        first;
    logic        last;
    logic [31:0] value;
  } beat_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] rslot;
    logic [6:0] placed;
    logic [6:0] occ;
    logic       status;
    logic       bdone;
  } table_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  command;
  logic [5:0]  slot;
  logic [6:0]  range_length;
  logic        first_of_put;
  logic        last_of_put;
  logic [31:0] value;
  logic        done;
  logic        hit;
  logic [5:0]  result_slot;
  logic [6:0]  placed_total;
  logic [6:0]  occupied_count;
  logic        status;
  logic        burst_done;

  logic [31:0] tbl_value [SLOTS];
  bit          tbl_full [SLOTS];
  int          fill_pos;
  int          fill_stop;
  int          burst_count;
  int          full_slots;

  table_result_t pending_results[$];
  int          mismatches;
  int          beats_sent;
  int          burst_left;
  int          cycle_count;

  sparse_slot_table uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .slot           (slot),
    .range_length   (range_length),
    .first_of_put   (first_of_put),
    .last_of_put    (last_of_put),
    .value          (value),
    .done           (done),
    .hit            (hit),
    .result_slot    (result_slot),
    .placed_total   (placed_total),
    .occupied_count (occupied_count),
    .status         (status),
    .burst_done     (burst_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic table_result_t apply_table_op(beat_t b);
    table_result_t r;
    int i;
    int stop;
    bit placed_now;
    r = '0;
    placed_now = 1'b0;
    case (b.command)
      CMD_PUT: begin
        if (b.first) begin
          stop = int'(b.slot) + int'(b.range_length);
          if (stop > SLOTS) begin
            r.status = (b.range_length != 0);
            stop = SLOTS;
          end
          fill_pos = int'(b.slot);
          fill_stop = stop;
          burst_count = 0;
        end
        for (i = fill_pos; i < fill_stop && !placed_now; i++) begin
          if (!tbl_full[i]) begin
            tbl_value[i] = b.value;
            tbl_full[i] = 1'b1;
            full_slots++;
            burst_count++;
            placed_now = 1'b1;
            r.hit = 1'b1;
            r.rslot = 6'(i);
          end
        end
        fill_pos = placed_now ? int'(r.rslot) + 1 : fill_stop;
        if (b.last) fill_pos = fill_stop;
        r.bdone = b.last;
      end
      CMD_LOOKUP: begin
        for (i = 0; i < SLOTS; i++) begin
          if (!r.hit && tbl_full[i] && tbl_value[i] == b.value) begin
            r.hit = 1'b1;
            r.rslot = 6'(i);
          end
        end
      end
      CMD_DELETE: begin
        if (tbl_full[b.slot]) begin
          tbl_full[b.slot] = 1'b0;
          full_slots--;
          r.hit = 1'b1;
          r.rslot = b.slot;
        end
      end
      default: begin
      end
    endcase
    r.placed = 7'(burst_count);
    r.occ = 7'(full_slots);
    return r;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_full_slot();
    int base;
    int i;
    base = $urandom_range(0, SLOTS - 1);
    for (i = 0; i < SLOTS; i++) begin
      if (tbl_full[(base + i) % SLOTS]) return (base + i) % SLOTS;
    end
    return base;
  endfunction

  function automatic logic [31:0] pick_stored_value();
    int idx;
    idx = pick_full_slot();
    return tbl_full[idx] ? tbl_value[idx] : rand_value();
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    b.command = 2'($urandom_range(0, 2));
    b.slot = 6'($urandom_range(0, SLOTS - 1));
    b.range_length = 7'($urandom_range(0, SLOTS));
    b.first = 1'($urandom_range(0, 1));
    b.last = 1'($urandom_range(0, 1));
    b.value = rand_value();
    return b;
  endfunction

  function automatic beat_t make_beat(logic [1:0] cmd, logic [5:0] s, logic [6:0] len,
                                      logic f, logic l, logic [31:0] v);
    beat_t b;
    b.command = cmd;
    b.slot = s;
    b.range_length = len;
    b.first = f;
    b.last = l;
    b.value = v;
    return b;
  endfunction

  // Called at a rising edge; start is left high so back-to-back beats never
  // toggle it within one time step.
  task automatic send_beat(beat_t b);
    start <= 1'b1;
    command <= b.command;
    slot <= b.slot;
    range_length <= b.range_length;
    first_of_put <= b.first;
    last_of_put <= b.last;
    value <= b.value;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_table_op(b));
    if (b.command != CMD_UNUSED) beats_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 5);
    end
  endtask

  task automatic send_lookup();
    beat_t b;
    b = random_beat();
    b.command = CMD_LOOKUP;
    b.value = ($urandom_range(0, 3) != 0) ? pick_stored_value() : rand_value();
    send_beat(b);
  endtask

  task automatic send_delete();
    beat_t b;
    b = random_beat();
    b.command = CMD_DELETE;
    b.slot = 6'(($urandom_range(0, 3) != 0) ? pick_full_slot() : $urandom_range(0, SLOTS - 1));
    send_beat(b);
  endtask

  task automatic send_put_burst(bit closed);
    beat_t b;
    int len;
    int n;
    int k;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, SLOTS) : $urandom_range(1, 12);
    n = $urandom_range(1, (len > 16 ? 16 : len) + 2);
    for (k = 0; k < n; k++) begin
      b = random_beat();
      b.command = CMD_PUT;
      b.first = (k == 0);
      b.last = closed && (k == n - 1);
      if (k == 0) b.range_length = 7'(len);
      send_beat(b);
      if (k < n - 1 && $urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1)) send_lookup();
        else send_delete();
      end
    end
  endtask

  task automatic test_put_without_burst();
    send_beat(make_beat(CMD_PUT, 6'd5, 7'd3, 1'b0, 1'b0, 32'h1234_5678));
    send_beat(make_beat(CMD_PUT, 6'd0, 7'd64, 1'b0, 1'b1, 32'hFFFF_FFFF));
  endtask

  task automatic test_basic_burst();
    send_beat(make_beat(CMD_PUT, 6'd0, 7'd3, 1'b1, 1'b0, 32'h0000_0000));
    send_beat(make_beat(CMD_PUT, 6'd0, 7'd0, 1'b0, 1'b0, 32'hFFFF_FFFF));
    send_beat(make_beat(CMD_PUT, 6'd0, 7'd0, 1'b0, 1'b1, 32'hA5A5_A5A5));
    send_beat(make_beat(CMD_PUT, 6'd7, 7'd2, 1'b0, 1'b0, 32'h5A5A_5A5A));
  endtask

  task automatic test_lookup_delete();
    send_beat(make_beat(CMD_LOOKUP, 6'd63, 7'd64, 1'b1, 1'b1, 32'hFFFF_FFFF));
    send_beat(make_beat(CMD_LOOKUP, 6'd0, 7'd0, 1'b0, 1'b0, 32'h0000_0000));
    send_beat(make_beat(CMD_LOOKUP, 6'd0, 7'd0, 1'b0, 1'b0, 32'h0001_2345));
    send_beat(make_beat(CMD_DELETE, 6'd1, 7'd0, 1'b0, 1'b0, 32'h0000_0000));
    send_beat(make_beat(CMD_DELETE, 6'd1, 7'd64, 1'b1, 1'b1, 32'hFFFF_FFFF));
    send_beat(make_beat(CMD_LOOKUP, 6'd0, 7'd0, 1'b0, 1'b0, 32'hFFFF_FFFF));
  endtask

  task automatic test_skip_full_and_exhaust();
    send_beat(make_beat(CMD_PUT, 6'd0, 7'd4, 1'b1, 1'b0, 32'h0000_0011));
    send_beat(make_beat(CMD_LOOKUP, 6'd0, 7'd0, 1'b0, 1'b0, 32'h0000_0011));
    send_beat(make_beat(CMD_PUT, 6'd0, 7'd0, 1'b0, 1'b0, 32'h0000_0022));
    send_beat(make_beat(CMD_DELETE, 6'd63, 7'd0, 1'b0, 1'b0, 32'h0000_0000));
    send_beat(make_beat(CMD_PUT, 6'd0, 7'd0, 1'b0, 1'b1, 32'h0000_0033));
  endtask

  task automatic test_range_past_capacity();
    int k;
    send_beat(make_beat(CMD_PUT, 6'd60, 7'd64, 1'b1, 1'b0, 32'h8000_0000));
    for (k = 0; k < 4; k++) begin
      send_beat(make_beat(CMD_PUT, 6'd0, 7'd0, 1'b0, 1'b0, rand_value()));
    end
    send_beat(make_beat(CMD_PUT, 6'd0, 7'd0, 1'b0, 1'b1, 32'h0000_0001));
  endtask

  task automatic test_empty_and_full_range();
    send_beat(make_beat(CMD_PUT, 6'd63, 7'd0, 1'b1, 1'b1, 32'h7FFF_FFFF));
    send_beat(make_beat(CMD_PUT, 6'd0, 7'd64, 1'b1, 1'b1, 32'hFFFF_FFFF));
  endtask

  task automatic test_unused_command();
    send_beat(make_beat(CMD_UNUSED, 6'd63, 7'd64, 1'b1, 1'b1, 32'hFFFF_FFFF));
  endtask

  task automatic test_whole_table_fill();
    beat_t b;
    int i;
    for (i = 0; i < SLOTS; i++) begin
      if (tbl_full[i]) begin
        b = random_beat();
        b.command = CMD_DELETE;
        b.slot = 6'(i);
        send_beat(b);
      end
    end
    for (i = 0; i < SLOTS; i++) begin
      b = random_beat();
      b.command = CMD_PUT;
      b.first = (i == 0);
      b.last = (i == SLOTS - 1);
      if (i == 0) begin
        b.slot = '0;
        b.range_length = 7'(SLOTS);
      end
      send_beat(b);
    end
    send_lookup();
  endtask

  task automatic test_random_traffic(int count);
    beat_t b;
    int target;
    int roll;
    target = beats_sent + count;
    while (beats_sent < target) begin
      roll = $urandom_range(0, 99);
      if (full_slots > 48 && roll < 55) roll = 80;
      if (roll < 55) begin
        send_put_burst(1'b1);
      end else if (roll < 75) begin
        send_lookup();
      end else if (roll < 90) begin
        send_delete();
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            b = random_beat();
            b.command = CMD_PUT;
            b.first = 1'b0;
            send_beat(b);
          end
          1: begin
            b = random_beat();
            b.command = CMD_UNUSED;
            send_beat(b);
          end
          default: send_put_burst(1'b0);
        endcase
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    table_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("done beat with no result expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          mismatches++;
        end
        if (result_slot !== want.rslot) begin
          $error("result_slot: expected %0d, got %0d", want.rslot, result_slot);
          mismatches++;
        end
        if (placed_total !== want.placed) begin
          $error("placed_total: expected %0d, got %0d", want.placed, placed_total);
          mismatches++;
        end
        if (occupied_count !== want.occ) begin
          $error("occupied_count: expected %0d, got %0d", want.occ, occupied_count);
          mismatches++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (burst_done !== want.bdone) begin
          $error("burst_done: expected %0d, got %0d", want.bdone, burst_done);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    command <= '0;
    slot <= '0;
    range_length <= '0;
    first_of_put <= 1'b0;
    last_of_put <= 1'b0;
    value <= '0;
    burst_left = 3;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_put_without_burst();
    test_basic_burst();
    test_lookup_delete();
    test_skip_full_and_exhaust();
    test_range_past_capacity();
    test_empty_and_full_range();
    test_unused_command();
    test_random_traffic(450);
    test_whole_table_fill();
    test_random_traffic(450);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
